// ===== hdl/masked_mean_and_coeff_of_variation_assert.svh =====
// Assertion macros for the masked mean and coefficient of variation block.
`ifndef MASKED_MEAN_AND_COEFF_OF_VARIATION_ASSERT_SVH
`define MASKED_MEAN_AND_COEFF_OF_VARIATION_ASSERT_SVH
`ifndef SYNTHESIS
`define MMCV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MMCV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MMCV_ASSERT_SAME(lbl, ante, cons)
`define MMCV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mmcv_pkg.sv =====
// Types and constants shared by the mean and coefficient of variation block.
`timescale 1ns / 1ps
package mmcv_pkg;
    localparam int DW     = 24;
    localparam int DIV_N  = 64;
    localparam int DIV_D  = 24;
    localparam logic signed [DW-1:0] CVAR_MAX = 24'sd8388607;

    typedef struct packed {
        logic signed [DW-1:0] sample;
        logic                 sample_is_nan;
        logic                 last;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] mean;
        logic signed [DW-1:0] cvar;
        logic [6:0]           valid_count;
        logic                 overflow;
    } out_t;

    typedef enum logic [0:0] {
        REG_USE_NODATA   = 1'b0,
        REG_NODATA_VALUE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_CVAR
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_PROD,
        S_MSTART,
        S_MWAIT,
        S_VSTART,
        S_VWAIT,
        S_SSTART,
        S_SWAIT,
        S_CSTART,
        S_CWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     take;
        logic     acc;
        logic     prod;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
        logic     sqrt_start;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic acc_last;
        logic div_busy;
        logic div_done;
        logic sqrt_busy;
        logic out_busy;
    } sts_t;
endpackage

// ===== hdl/masked_mean_and_coeff_of_variation.sv =====
// Top level: masked temporal mean and coefficient of variation of a pixel series.
//
//  channel  signals                              transfer when
//  in       in_valid in_ready in_data            in_valid && in_ready
//  out      out_valid out_ready out_data         out_valid && out_ready
//  cfg      cfg_valid cfg_ready cfg_index/data   cfg_valid && cfg_ready
//
// A sample is captured, then multiply-accumulated.
// A last sample then runs the products, then the mean, variance, root and ratio steps on the
// shared one-bit-per-cycle divider and the two-bit-per-cycle root, then waits for a free output.
// The result sits in an output register; the next series starts while it waits.
// Reset clears the accumulators and config; no clearing pass is needed.
`timescale 1ns / 1ps
`include "masked_mean_and_coeff_of_variation_assert.svh"
module masked_mean_and_coeff_of_variation
    import mmcv_pkg::*;
#(
    parameter int MAX_IMAGES = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_t           in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output out_t          out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  cfg_idx_t      cfg_index,
    input  logic [DW-1:0] cfg_data
);
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    mmcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmcv_dp #(
        .MAX_IMAGES (MAX_IMAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `MMCV_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `MMCV_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
    `MMCV_ASSERT_SAME(a_div_free, cmd.div_start, !sts.div_busy)
endmodule

// ===== hdl/mmcv_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mmcv_div
    import mmcv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_N-1:0] dividend,
    input  logic [DIV_D-1:0] divisor,
    output logic [DIV_N-1:0] quotient,
    output logic             busy,
    output logic             done
);
    localparam int CNTW = $clog2(DIV_N);

    logic [DIV_N-1:0] dq_reg, dq_next;
    logic [DIV_D-1:0] rem_reg, rem_next;
    logic [DIV_D-1:0] dvs_reg;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_D:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dq_reg[DIV_N-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        rem_next  = ge ? DIV_D'(rem_sh - {1'b0, dvs_reg}) : DIV_D'(rem_sh);
        dq_next   = {dq_reg[DIV_N-2:0], ge};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != '0);
        done_next = busy_reg && (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(DIV_N - 1);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dq_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
endmodule

// ===== hdl/mmcv_ctrl.sv =====
// Sequencer for accumulation and the per-series divide and square root steps.
`timescale 1ns / 1ps
module mmcv_ctrl
    import mmcv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.acc_last ? S_PROD : S_IDLE;
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_VSTART;
                end
            end
            S_VSTART:
            begin
                cmd.div_sel   = DIV_VAR;
                cmd.div_start = 1'b1;
                state_next    = S_VWAIT;
            end
            S_VWAIT:
            begin
                cmd.div_sel = DIV_VAR;
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_SSTART;
                end
            end
            S_SSTART:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = S_CSTART;
                end
            end
            S_CSTART:
            begin
                cmd.div_sel   = DIV_CVAR;
                cmd.div_start = 1'b1;
                state_next    = S_CWAIT;
            end
            S_CWAIT:
            begin
                cmd.div_sel = DIV_CVAR;
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/mmcv_dp.sv =====
// Datapath: accumulators, products, square root, result register and config.
`timescale 1ns / 1ps
module mmcv_dp
    import mmcv_pkg::*;
#(
    parameter int MAX_IMAGES = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  in_t             in_data,
    input  cmd_t            cmd,
    output sts_t            sts,
    input  logic            cfg_we,
    input  cfg_idx_t        cfg_index,
    input  logic [DW-1:0]   cfg_data,
    output logic            out_valid,
    input  logic            out_ready,
    output out_t            out_data
);
    localparam int CW = $clog2(MAX_IMAGES + 1);
    localparam int SW = DW + CW;
    localparam int QW = 2 * DW - 1 + CW;

    logic                 use_nodata_reg;
    logic [DW-1:0]        nodata_reg;

    logic signed [DW-1:0] sample_reg;
    logic                 nan_reg;
    logic                 last_reg;

    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0]        sqsum_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 drop_reg;

    logic [DIV_N-1:0]     a_reg, b_reg, mdiv_reg, var_reg, cq_reg;
    logic [DIV_D-1:0]     nn1_reg;
    logic [DW-1:0]        mean_reg;

    logic [DIV_N-1:0]     x_reg, r_reg;
    logic [DIV_N-2:0]     bit_reg;
    logic                 sqrt_busy_reg;

    logic                 out_valid_reg;
    out_t                 out_reg;

    logic                 sample_ok;
    logic                 full;
    logic signed [2*DW-1:0] sq_s;
    logic [CW+QW-1:0]     prod_a;
    logic [SW-2:0]        mag;
    logic [2*SW-3:0]      prod_b;
    logic [2*CW-1:0]      nn1;
    logic [DIV_N-1:0]     num;
    logic [DIV_N-1:0]     div_dividend;
    logic [DIV_D-1:0]     div_divisor;
    logic [DIV_N-1:0]     quotient;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_N-1:0]     rb;
    logic                 sq_ge;
    logic signed [DW-1:0] fill;
    logic                 pos;
    logic signed [DW-1:0] cvar_sat;
    logic [8:0]           cnt9;
    out_t                 res;

    always_comb
    begin
        sample_ok = !nan_reg && !(use_nodata_reg && (sample_reg == nodata_reg));
        full      = cnt_reg == CW'(MAX_IMAGES);
        sq_s      = sample_reg * sample_reg;
        prod_a    = cnt_reg * sqsum_reg;
        mag       = sum_reg[SW-2:0];
        prod_b    = mag * mag;
        nn1       = cnt_reg * (cnt_reg - 1'b1);
        num       = (a_reg > b_reg) ? a_reg - b_reg : '0;
        rb        = r_reg + DIV_N'(bit_reg);
        sq_ge     = x_reg >= rb;
        case (cmd.div_sel)
            DIV_VAR:
            begin
                div_dividend = num;
                div_divisor  = nn1_reg;
            end
            DIV_CVAR:
            begin
                div_dividend = (DIV_N'(r_reg[31:0]) << 16) + DIV_N'(mean_reg[DW-1:1]);
                div_divisor  = DIV_D'(mean_reg);
            end
            default:
            begin
                div_dividend = mdiv_reg;
                div_divisor  = DIV_D'(cnt_reg);
            end
        endcase
        fill     = use_nodata_reg ? $signed(nodata_reg) : '0;
        pos      = (cnt_reg != '0) && !sum_reg[SW-1] && (sum_reg != '0);
        cvar_sat = (cq_reg > DIV_N'(CVAR_MAX)) ? CVAR_MAX : $signed(cq_reg[DW-1:0]);
        cnt9     = 9'(cnt_reg);
        res.valid_count = cnt9[6:0];
        res.overflow    = drop_reg;
        if (!pos)
        begin
            res.mean = fill;
            res.cvar = fill;
        end
        else
        begin
            res.mean = $signed(mean_reg);
            if (cnt_reg == CW'(1))
            begin
                res.cvar = fill;
            end
            else if (mean_reg == '0)
            begin
                res.cvar = CVAR_MAX;
            end
            else
            begin
                res.cvar = cvar_sat;
            end
        end
    end

    mmcv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_nodata_reg <= 1'b0;
            nodata_reg     <= '0;
            sum_reg        <= '0;
            sqsum_reg      <= '0;
            cnt_reg        <= '0;
            drop_reg       <= 1'b0;
            sqrt_busy_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_USE_NODATA:   use_nodata_reg <= cfg_data[0];
                    REG_NODATA_VALUE: nodata_reg     <= cfg_data;
                    default:          use_nodata_reg <= use_nodata_reg;
                endcase
            end
            if (cmd.acc && sample_ok)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    sum_reg   <= sum_reg + SW'(sample_reg);
                    sqsum_reg <= sqsum_reg + QW'($unsigned(sq_s));
                    cnt_reg   <= cnt_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                sum_reg   <= '0;
                sqsum_reg <= '0;
                cnt_reg   <= '0;
                drop_reg  <= 1'b0;
            end
            if (cmd.sqrt_start)
            begin
                sqrt_busy_reg <= 1'b1;
            end
            else if (sqrt_busy_reg && bit_reg[0])
            begin
                sqrt_busy_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= in_data.sample;
            nan_reg    <= in_data.sample_is_nan;
            last_reg   <= in_data.last;
        end
        if (cmd.prod)
        begin
            a_reg    <= DIV_N'(prod_a);
            b_reg    <= DIV_N'(prod_b);
            nn1_reg  <= DIV_D'(nn1);
            mdiv_reg <= DIV_N'(mag) + DIV_N'(cnt_reg >> 1);
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_VAR:  var_reg  <= quotient;
                DIV_CVAR: cq_reg   <= quotient;
                default:  mean_reg <= quotient[DW-1:0];
            endcase
        end
        if (cmd.sqrt_start)
        begin
            x_reg   <= var_reg;
            r_reg   <= '0;
            bit_reg <= {1'b1, {(DIV_N-2){1'b0}}};
        end
        else if (sqrt_busy_reg)
        begin
            if (sq_ge)
            begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + DIV_N'(bit_reg);
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.load_out)
        begin
            out_reg <= res;
        end
    end

    assign sts.acc_last  = last_reg;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.sqrt_busy = sqrt_busy_reg;
    assign sts.out_busy  = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
endmodule

// ===== bench/mmcv_checker.sv =====
// Checker: watches the channels of the mean/cvar block, predicts results and compares them.
`timescale 1ns / 1ps
module mmcv_checker
    import mmcv_pkg::*;
#(
    parameter int MAX_IMAGES = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  in_t           in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  out_t          out_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  cfg_idx_t      cfg_index,
    input  logic [DW-1:0] cfg_data,
    output int            errors,
    output int            pending,
    output int            results_seen
);
    logic                 mask_on;
    logic signed [DW-1:0] nodata;
    longint               acc_sum;
    longint unsigned      acc_sq;
    int unsigned          acc_n;
    logic                 acc_drop;
    out_t                 expected_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_t series_stats();
        out_t            res;
        longint          fill;
        longint          mean;
        longint          cv;
        longint unsigned n;
        longint unsigned s;
        longint unsigned a;
        longint unsigned b;
        longint unsigned var_q;
        longint unsigned sd;
        longint unsigned q;
        fill = mask_on ? longint'(nodata) : 0;
        mean = fill;
        cv = fill;
        n = acc_n;
        if (n > 0 && acc_sum > 0)
        begin
            s = acc_sum;
            mean = (s + n / 2) / n;
            if (n > 1)
            begin
                a = n * acc_sq;
                b = s * s;
                var_q = (a > b ? a - b : 0) / (n * (n - 1));
                sd = int_sqrt(var_q);
                if (mean <= 0)
                    cv = 8388607;
                else
                begin
                    q = ((sd << 16) + longint'(mean) / 2) / longint'(mean);
                    cv = q > 8388607 ? 8388607 : q;
                end
            end
        end
        res.mean = mean[DW-1:0];
        res.cvar = cv[DW-1:0];
        res.valid_count = n[6:0];
        res.overflow = acc_drop;
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_on = 0;
            nodata = 0;
            acc_sum = 0;
            acc_sq = 0;
            acc_n = 0;
            acc_drop = 0;
            errors = 0;
            results_seen = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_USE_NODATA)
                    mask_on = cfg_data[0];
                else
                    nodata = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, out_data);
                end
                else
                begin
                    out_t e;
                    e = expected_q.pop_front();
                    if (e !== out_data)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (!in_data.sample_is_nan && !(mask_on && in_data.sample == nodata))
                begin
                    if (acc_n < MAX_IMAGES)
                    begin
                        acc_sum += longint'(in_data.sample);
                        acc_sq += longint'(in_data.sample) * longint'(in_data.sample);
                        acc_n++;
                    end
                    else
                        acc_drop = 1;
                end
                if (in_data.last)
                begin
                    expected_q.push_back(series_stats());
                    acc_sum = 0;
                    acc_sq = 0;
                    acc_n = 0;
                    acc_drop = 0;
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives series and configuration into the mean/cvar block and gives the verdict.
`timescale 1ns / 1ps
module testbench;
    import mmcv_pkg::*;

    localparam int LIMIT = 20000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    in_t           in_data;
    logic          out_valid;
    logic          out_ready;
    out_t          out_data;
    logic          cfg_valid;
    logic          cfg_ready;
    cfg_idx_t      cfg_index;
    logic [DW-1:0] cfg_data;
    int            errors;
    int            pending;
    int            results_seen;
    int            in_idle_pct;
    int            out_idle_pct;
    int            hold_off;
    int            items_sent;
    int            quiet;
    logic          stall_go;
    logic          stall_done;
    logic signed [DW-1:0] cur_nodata;

    masked_mean_and_coeff_of_variation #(.MAX_IMAGES(64)) DUT (.*);

    mmcv_checker #(.MAX_IMAGES(64)) checker_i (.*);

    initial clk = 0;
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            hold_off <= 0;
            stall_done <= 0;
        end
        else if (stall_go && !stall_done)
        begin
            out_ready <= 0;
            hold_off <= 2000;
            stall_done <= 1;
        end
        else if (hold_off > 0)
        begin
            out_ready <= 0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(input logic signed [DW-1:0] s, input logic nan, input logic lst);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= '{sample: s, sample_is_nan: nan, last: lst};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DW-1:0] val);
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        if (idx == REG_NODATA_VALUE)
            cur_nodata = val;
    endtask

    task automatic rand_series();
        int len;
        int k;
        int mode;
        logic signed [DW-1:0] s;
        mode = $urandom_range(9);
        len = (mode == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(5))
                0: s = DW'($urandom);
                1: s = cur_nodata;
                2: s = DW'($urandom_range(3));
                default: s = (mode < 3) ? DW'($urandom) : DW'($urandom_range(1 << 20));
            endcase
            send(s, ($urandom_range(15) == 0), (k == len - 1));
        end
    endtask

    initial
    begin
        int ph;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = REG_USE_NODATA;
        cfg_data = '0;
        stall_go = 0;
        items_sent = 0;
        cur_nodata = 0;
        in_idle_pct = 14;
        out_idle_pct = 69;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, empty, single, masked, nan, zero mean, overflow
        send(24'sh7FFFFF, 0, 0);
        send(24'sh7FFFFF, 0, 1);
        send(24'sh800000, 0, 1);
        send(24'sh000005, 1, 1);
        send(24'sh010000, 0, 1);
        send(24'sh000001, 0, 0);
        send(24'sh000000, 0, 0);
        send(24'sh000000, 0, 1);
        send(-24'sd5, 0, 0);
        send(24'sd3, 0, 1);
        write_reg(REG_NODATA_VALUE, 24'hFF0000);
        write_reg(REG_USE_NODATA, 24'd1);
        send(24'shFF0000, 0, 0);
        send(24'sh020000, 0, 0);
        send(24'sh030000, 0, 1);
        send(24'shFF0000, 0, 1);
        for (int k = 0; k < 66; k++)
            send(DW'(24'sh7FFFFF - k), 0, (k == 65));

        for (ph = 0; ph < 3; ph++)
        begin
            in_idle_pct = (ph == 0) ? 14 : (ph == 1 ? 69 : 0);
            out_idle_pct = (ph == 0) ? 69 : (ph == 1 ? 14 : 0);
            write_reg(REG_USE_NODATA, DW'(ph[0]));
            write_reg(REG_NODATA_VALUE, (ph == 2) ? 24'h7FFFFF : DW'($urandom));
            if (ph == 1)
                stall_go <= 1;
            while (items_sent < 130 * (ph + 1))
                rand_series();
        end
        write_reg(REG_NODATA_VALUE, 24'h800000);
        write_reg(REG_USE_NODATA, 24'd1);
        send(24'sh800000, 0, 1);
        send(24'sh000002, 0, 1);
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Ran %0d samples, %0d results, over masking on/off, idle mixes and a long stall.",
                 items_sent, results_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
